// ===== src/irt_pkg.sv =====
package irt_pkg;

  localparam int unsigned AddrW = 128;
  localparam int unsigned TagW  = 32;

  // IPv4 addresses live at ::ffff:a.b.c.d, so the low word carries this prefix.
  localparam logic [63:0] V4_MAP_PREFIX = 64'h0000_ffff_0000_0000;

  typedef logic [AddrW-1:0] addr_t;
  typedef logic [TagW-1:0]  tag_t;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_DELETE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERLAP   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef struct packed {
    logic  valid;
    addr_t range_start;
    addr_t range_end;
    tag_t  range_tag;
  } entry_t;

endpackage

// ===== src/irt_if.sv =====
interface irt_req_if import irt_pkg::*;;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic        is_v6;
  logic [63:0] first_hi;
  logic [63:0] first_lo;
  logic [63:0] second_hi;
  logic [63:0] second_lo;
  tag_t        tag_in;

  modport source (
    output valid, operation, is_v6, first_hi, first_lo, second_hi, second_lo, tag_in,
    input  ready
  );
  modport sink (
    input  valid, operation, is_v6, first_hi, first_lo, second_hi, second_lo, tag_in,
    output ready
  );
endinterface

interface irt_rsp_if import irt_pkg::*;;
  logic    valid;
  logic    ready;
  status_e status;
  logic    hit;
  tag_t    tag_out;

  modport source (
    output valid, status, hit, tag_out,
    input  ready
  );
  modport sink (
    input  valid, status, hit, tag_out,
    output ready
  );
endinterface

// ===== src/ip_range_table_unit.sv =====
// Address range table.
// A request arrives on req_i (valid/ready) and names an insert, a lookup or a
// delete; each request gives exactly one response on rsp_o (valid/ready) with
// a status, a hit flag and a tag. Ranges are inclusive and non-overlapping;
// IPv4 bounds are mapped to ::ffff:a.b.c.d before any comparison.
// The addresses are latched and mapped at the accepting edge. An ordering
// step then puts the bounds in order. The scan reads one table entry per
// cycle from the entry memory through a registered read, and a commit step
// then loads the response register and makes any table update.
// Lookup and delete stop the scan at the first match; insert always walks the
// whole table, since it must rule out every overlap. The sequencer then goes
// back to idle. req_i.ready is high only while the sequencer is idle, so a
// request is accepted only after the previous one has committed.
// After reset the block clears the valid bit of every entry and accepts no
// request during that pass.
// A finished response sits in an output register. A new request may be
// accepted while it waits; if the receiver stalls, the next response waits in
// the commit step (and its table update with it) until rsp_o is free.
module ip_range_table_unit import irt_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  irt_req_if.sink         req_i,
  irt_rsp_if.source       rsp_o
);

  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_ENTRIES - 1);

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_ORDER  = 5'b00100,
    S_SCAN   = 5'b01000,
    S_COMMIT = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  logic [1:0]        op_q, op_d;
  addr_t             key_lo_q, key_lo_d;
  addr_t             key_hi_q, key_hi_d;
  tag_t              tag_q, tag_d;
  logic [IdxW-1:0]   issue_idx_q, issue_idx_d;
  logic              issue_done_q, issue_done_d;
  logic              pend_q, pend_d;
  logic [IdxW-1:0]   pend_idx_q, pend_idx_d;
  logic              found_q, found_d;
  logic              overlap_q, overlap_d;
  logic [IdxW-1:0]   match_idx_q, match_idx_d;
  tag_t              hit_tag_q, hit_tag_d;

  logic              rsp_valid_q, rsp_valid_d;
  status_e           rsp_status_q, rsp_status_d;
  logic              rsp_hit_q, rsp_hit_d;
  tag_t              rsp_tag_q, rsp_tag_d;

  // Entry memory: one write and one registered read per cycle.
  entry_t            mem_q [TABLE_ENTRIES];
  entry_t            rd_q;
  logic              mem_we;
  logic [IdxW-1:0]   mem_waddr;
  entry_t            mem_wdata;

  addr_t             req_a, req_b;
  addr_t             cmp_x0, cmp_y0, cmp_x1, cmp_y1;
  logic              lt0, lt1, covered, exact;

  // Map both request bounds into the 128-bit address space.
  always_comb begin
    if (req_i.is_v6) begin
      req_a = {req_i.first_hi, req_i.first_lo};
      req_b = {req_i.second_hi, req_i.second_lo};
    end else begin
      req_a = {64'h0, V4_MAP_PREFIX | {32'h0, req_i.first_lo[31:0]}};
      req_b = {64'h0, V4_MAP_PREFIX | {32'h0, req_i.second_lo[31:0]}};
    end
  end

  // Shared compare unit. While ordering, it checks whether the second bound
  // is below the first; while scanning, it tests the key range against the
  // entry that the memory has just delivered.
  always_comb begin
    if (state_q == S_ORDER) begin
      cmp_x0 = key_hi_q;
      cmp_y0 = key_lo_q;
    end else begin
      cmp_x0 = key_hi_q;
      cmp_y0 = rd_q.range_start;
    end
    cmp_x1  = rd_q.range_end;
    cmp_y1  = key_lo_q;
    lt0     = cmp_x0 < cmp_y0;
    lt1     = cmp_x1 < cmp_y1;
    covered = !lt0 && !lt1;
    exact   = (rd_q.range_start == key_lo_q) && (rd_q.range_end == key_hi_q);
  end

  assign req_i.ready   = (state_q == S_IDLE);
  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.status  = rsp_status_q;
  assign rsp_o.hit     = rsp_hit_q;
  assign rsp_o.tag_out = rsp_tag_q;

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    key_lo_d     = key_lo_q;
    key_hi_d     = key_hi_q;
    tag_d        = tag_q;
    issue_idx_d  = issue_idx_q;
    issue_done_d = issue_done_q;
    pend_d       = 1'b0;
    pend_idx_d   = pend_idx_q;
    found_d      = found_q;
    overlap_d    = overlap_q;
    match_idx_d  = match_idx_q;
    hit_tag_d    = hit_tag_q;
    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    rsp_status_d = rsp_status_q;
    rsp_hit_d    = rsp_hit_q;
    rsp_tag_d    = rsp_tag_q;
    mem_we       = 1'b0;
    mem_waddr    = issue_idx_q;
    mem_wdata    = '0;

    unique case (state_q)
      S_CLEAR: begin
        // issue_idx_q doubles as the sweep counter of the clearing pass.
        mem_we    = 1'b1;
        mem_waddr = issue_idx_q;
        if (issue_idx_q == LastIdx) begin
          issue_idx_d = '0;
          state_d     = S_IDLE;
        end else begin
          issue_idx_d = issue_idx_q + 1'b1;
        end
      end

      S_IDLE: begin
        if (req_i.valid) begin
          op_d         = req_i.operation;
          key_lo_d     = req_a;
          key_hi_d     = req_b;
          tag_d        = req_i.tag_in;
          issue_idx_d  = '0;
          issue_done_d = 1'b0;
          found_d      = 1'b0;
          overlap_d    = 1'b0;
          match_idx_d  = '0;
          hit_tag_d    = '0;
          state_d      = S_ORDER;
        end
      end

      S_ORDER: begin
        // After this step key_lo holds the range start and key_hi the end.
        // A lookup uses the first address as both.
        case (op_q)
          OP_INSERT, OP_DELETE: begin
            if (lt0) begin
              key_lo_d = key_hi_q;
              key_hi_d = key_lo_q;
            end
            state_d = S_SCAN;
          end
          OP_LOOKUP: begin
            key_hi_d = key_lo_q;
            state_d  = S_SCAN;
          end
          default: state_d = S_COMMIT;
        endcase
      end

      S_SCAN: begin
        if (!issue_done_q) begin
          pend_d     = 1'b1;
          pend_idx_d = issue_idx_q;
          if (issue_idx_q == LastIdx) begin
            issue_done_d = 1'b1;
          end else begin
            issue_idx_d = issue_idx_q + 1'b1;
          end
        end
        if (pend_q) begin
          case (op_q)
            OP_LOOKUP: begin
              if (rd_q.valid && covered) begin
                found_d   = 1'b1;
                hit_tag_d = rd_q.range_tag;
                state_d   = S_COMMIT;
              end
            end
            OP_INSERT: begin
              if (rd_q.valid) begin
                if (covered) begin
                  overlap_d = 1'b1;
                end
              end else if (!found_q) begin
                // Lowest free slot wins.
                found_d     = 1'b1;
                match_idx_d = pend_idx_q;
              end
            end
            OP_DELETE: begin
              if (rd_q.valid && exact) begin
                found_d     = 1'b1;
                match_idx_d = pend_idx_q;
                state_d     = S_COMMIT;
              end
            end
            default: state_d = S_COMMIT;
          endcase
          if (pend_idx_q == LastIdx) begin
            state_d = S_COMMIT;
          end
        end
      end

      S_COMMIT: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d  = 1'b1;
          rsp_hit_d    = 1'b0;
          rsp_tag_d    = '0;
          rsp_status_d = ST_NOT_FOUND;
          mem_waddr    = match_idx_q;
          case (op_q)
            OP_INSERT: begin
              if (overlap_q) begin
                rsp_status_d = ST_OVERLAP;
              end else if (!found_q) begin
                rsp_status_d = ST_FULL;
              end else begin
                rsp_status_d          = ST_OK;
                mem_we                = 1'b1;
                mem_wdata.valid       = 1'b1;
                mem_wdata.range_start = key_lo_q;
                mem_wdata.range_end   = key_hi_q;
                mem_wdata.range_tag   = tag_q;
              end
            end
            OP_LOOKUP: begin
              if (found_q) begin
                rsp_status_d = ST_OK;
                rsp_hit_d    = 1'b1;
                rsp_tag_d    = hit_tag_q;
              end
            end
            OP_DELETE: begin
              if (found_q) begin
                rsp_status_d = ST_OK;
                mem_we       = 1'b1;
              end
            end
            default: rsp_status_d = ST_NOT_FOUND;
          endcase
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem_q[issue_idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      issue_idx_q  <= '0;
      issue_done_q <= 1'b0;
      pend_q       <= 1'b0;
      found_q      <= 1'b0;
      overlap_q    <= 1'b0;
      rsp_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      issue_idx_q  <= issue_idx_d;
      issue_done_q <= issue_done_d;
      pend_q       <= pend_d;
      found_q      <= found_d;
      overlap_q    <= overlap_d;
      rsp_valid_q  <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    key_lo_q     <= key_lo_d;
    key_hi_q     <= key_hi_d;
    tag_q        <= tag_d;
    pend_idx_q   <= pend_idx_d;
    match_idx_q  <= match_idx_d;
    hit_tag_q    <= hit_tag_d;
    rsp_status_q <= rsp_status_d;
    rsp_hit_q    <= rsp_hit_d;
    rsp_tag_q    <= rsp_tag_d;
  end

  // The sequencer always sits in exactly one state.
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state is not one-hot");

  // Once the clearing pass is over it never starts again.
  a_clear_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_CLEAR) |=> (state_q != S_CLEAR))
    else $error("clearing pass re-entered");

  // A hit always reports success, and only a hit carries a tag.
  a_hit_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && (rsp_hit_q || (rsp_tag_q != '0))) |->
      (rsp_hit_q && (rsp_status_q == ST_OK)))
    else $error("tag or hit flag on a response that is not a successful lookup");

  // The table changes only while clearing or on a successful insert or delete.
  a_write_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> ((state_q == S_CLEAR) ||
                ((state_q == S_COMMIT) && found_q && !overlap_q && rsp_valid_d)))
    else $error("unexpected entry memory write");

endmodule
